FILE: rtl/psd_pkg.sv
`default_nettype none
package psd_pkg;

  localparam int unsigned SampleW = 8;
  localparam int unsigned CoefW = 16;
  localparam int unsigned AccW = 28;
  localparam int unsigned StepW = 6;
  localparam int unsigned CfgW = 5;
  localparam int unsigned DefaultMaxSteps = 16;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned CordicIters = 24;
  localparam int unsigned RootIters = 28;
  localparam int unsigned DivW = 30;
  localparam int unsigned PhaseLimit = 25736;
  localparam logic [33:0] HalfPiQ30 = 34'd1686629713;
  localparam logic [CfgW-1:0] StepsReset = 5'd4;
  localparam real TwoPi = 6.28318530717958647692;

  typedef struct packed {
    logic [AccW-1:0]  sin_sum;
    logic [AccW-1:0]  cos_sum;
    logic [StepW-1:0] steps;
  } job_t;

  localparam logic [31:0] AtanTab [CordicIters] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
  };

  function automatic logic [CoefW-1:0] q15_round(input real v);
    int q;
    begin
      if (v >= 0.0) q = $rtoi(v * 32768.0 + 0.5);
      else q = -$rtoi(-v * 32768.0 + 0.5);
      if (q > 32767) q = 32767;
      if (q < -32767) q = -32767;
      q15_round = CoefW'(q);
    end
  endfunction

  // Upper half holds sin(ang), lower half cos(ang), both Q1.15.
  function automatic logic [2*CoefW-1:0] coef_word(input real ang);
    begin
      coef_word = {q15_round($sin(ang)), q15_round($cos(ang))};
    end
  endfunction

endpackage
`default_nettype wire

FILE: rtl/phase_shift_demodulator_core.sv
`default_nettype none
// Channel        Direction  Contents
// s_axis         in         tdata[7:0] sample
// m_axis         out        tdata[15:0] phase, tdata[31:16] modulation
// apb            in/out     num_steps at byte address 0
// Samples are taken one per cycle; the multiply-accumulate runs in the transfer cycle.
// Each pixel's sums go into a two-entry queue; the back end takes one pixel at a time
// through pop, square, sum, 28 root iterations shared with 24 CORDIC steps, a 30-step
// divide, the modulation load and the transfer.
// The input stalls only when the queue is full; the result waits in the output register.
// Reset is synchronous and sets num_steps to 4 with empty accumulators.
module phase_shift_demodulator_core #(
  parameter int unsigned MAX_STEPS = psd_pkg::DefaultMaxSteps
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] sample
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // [15:0] phase, [31:16] modulation
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import psd_pkg::*;

  logic [CfgW-1:0] num_steps;
  logic push, full, pop, empty;
  job_t push_data, pop_data;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {27'd0, num_steps} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) num_steps <= StepsReset;
    else if (psel && penable && pwrite && paddr[2] == 1'b0) num_steps <= pwdata[CfgW-1:0];
  end

  psd_front #(.MaxSteps(MAX_STEPS)) u_front (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .num_steps, .full, .push, .push_data
  );

  psd_queue u_queue (
    .clk, .rst, .push, .push_data, .full, .pop, .empty, .pop_data
  );

  psd_back u_back (
    .clk, .rst, .empty, .pop_data, .pop, .m_tvalid, .m_tready, .m_tdata
  );

endmodule
`default_nettype wire

FILE: rtl/psd_front.sv
`default_nettype none
module psd_front #(
  parameter int unsigned MaxSteps = psd_pkg::DefaultMaxSteps
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  input  wire logic [psd_pkg::SampleW-1:0] s_tdata,
  input  wire logic [psd_pkg::CfgW-1:0]   num_steps,
  input  wire logic                       full,
  output logic                            push,
  output psd_pkg::job_t                   push_data
);
  import psd_pkg::*;

  localparam int unsigned IdxW = $clog2(MaxSteps);

  logic [2*CoefW-1:0] rom [2**StepW][2**(IdxW+1)];
  logic [IdxW-1:0] idx;
  logic [IdxW:0] idx_inc;
  logic [StepW-1:0] n;
  logic last, accept;
  logic [AccW-1:0] acc_s, acc_c, acc_s_next, acc_c_next;
  logic signed [CoefW-1:0] sn, cs;
  logic signed [SampleW+CoefW:0] prod_s, prod_c;

  // The table is indexed by the incremented sample index, which may exceed n
  // after a step-count change, so each entry folds its index back modulo n.
  for (genvar gn = 0; gn < 2**StepW; gn++) begin : g_n
    for (genvar gm = 0; gm < 2**(IdxW+1); gm++) begin : g_m
      if (gn >= 3 && gn <= MaxSteps && gm <= MaxSteps) begin : g_v
        localparam int unsigned Mi = gm % gn;
        localparam real Ang = TwoPi * real'(Mi) / real'(gn);
        assign rom[gn][gm] = coef_word(Ang);
      end else begin : g_z
        assign rom[gn][gm] = '0;
      end
    end
  end

  always_comb begin
    if (num_steps < CfgW'(3)) n = StepW'(3);
    else if (StepW'(num_steps) > StepW'(MaxSteps)) n = StepW'(MaxSteps);
    else n = StepW'(num_steps);
  end

  assign idx_inc = {1'b0, idx} + 1'b1;
  assign last = (StepW'(idx_inc) >= n);
  assign sn = rom[n][idx_inc][2*CoefW-1:CoefW];
  assign cs = rom[n][idx_inc][CoefW-1:0];
  assign prod_s = $signed({1'b0, s_tdata}) * sn;
  assign prod_c = $signed({1'b0, s_tdata}) * cs;
  assign acc_s_next = acc_s + AccW'(prod_s);
  assign acc_c_next = acc_c + AccW'(prod_c);

  assign s_tready = !full;
  assign accept = s_tvalid && s_tready;
  assign push = accept && last;
  assign push_data = '{sin_sum: acc_s_next, cos_sum: acc_c_next, steps: n};

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
      acc_s <= '0;
      acc_c <= '0;
    end else if (accept) begin
      if (last) begin
        idx <= '0;
        acc_s <= '0;
        acc_c <= '0;
      end else begin
        idx <= idx_inc[IdxW-1:0];
        acc_s <= acc_s_next;
        acc_c <= acc_c_next;
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/psd_queue.sv
`default_nettype none
module psd_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  psd_pkg::job_t      push_data,
  output logic               full,
  input  wire logic          pop,
  output logic               empty,
  output psd_pkg::job_t      pop_data
);
  import psd_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);

  job_t mem [QueueDepth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [PtrW:0] count;

  assign full = (count == (PtrW+1)'(QueueDepth));
  assign empty = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push && !full) wr_ptr <= (wr_ptr == PtrW'(QueueDepth-1)) ? '0 : wr_ptr + 1'b1;
      if (pop && !empty) rd_ptr <= (rd_ptr == PtrW'(QueueDepth-1)) ? '0 : rd_ptr + 1'b1;
      count <= count + (PtrW+1)'(push && !full) - (PtrW+1)'(pop && !empty);
    end
  end

endmodule
`default_nettype wire

FILE: rtl/psd_back.sv
`default_nettype none
module psd_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          empty,
  input  psd_pkg::job_t      pop_data,
  output logic               pop,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [31:0]        m_tdata
);
  import psd_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SQR  = 6'b000010,
    ST_SUM  = 6'b000100,
    ST_ITER = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_OUT  = 6'b100000
  } state_t;

  state_t state;
  job_t job;
  logic [4:0] cnt;
  logic zero_vec;
  logic [2*AccW-1:0] sq_s, sq_c;
  logic [2*AccW:0] rad, res, bitv, trial;
  logic signed [63:0] x, y, dx, dy, x0, y0;
  logic signed [33:0] z, z0, za;
  logic [33:0] zq;
  logic [15:0] phase, modu;
  logic [DivW-1:0] dividend;
  logic [StepW:0] rem, rem_sh;
  logic signed [AccW-1:0] s_v, c_v;
  logic signed [2*AccW-1:0] s_w, c_w;

  assign s_v = $signed(job.sin_sum);
  assign c_v = $signed(job.cos_sum);
  assign s_w = (2*AccW)'(s_v);
  assign c_w = (2*AccW)'(c_v);
  assign pop = (state == ST_IDLE) && !empty;
  assign m_tvalid = (state == ST_OUT) && (cnt != 5'd0);
  assign m_tdata = {modu, phase};

  always_comb begin
    x0 = {{4{c_v[AccW-1]}}, c_v, 32'd0};
    y0 = -{{4{s_v[AccW-1]}}, s_v, 32'd0};
    z0 = '0;
    if (x0 < 0) begin
      if (y0 >= 0) begin
        x0 = y0;
        y0 = -{{4{c_v[AccW-1]}}, c_v, 32'd0};
        z0 = $signed(HalfPiQ30);
      end else begin
        x0 = {{4{s_v[AccW-1]}}, s_v, 32'd0};
        y0 = {{4{c_v[AccW-1]}}, c_v, 32'd0};
        z0 = -$signed(HalfPiQ30);
      end
    end
  end

  assign dx = y >>> cnt;
  assign dy = x >>> cnt;
  assign bitv = (2*AccW+1)'(1) << (2*(RootIters - 1 - cnt));
  assign trial = res + bitv;
  assign za = z[33] ? -z : z;
  assign zq = (za + 34'd65536) >> 17;
  assign rem_sh = {rem[StepW-1:0], dividend[DivW-1]};

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: if (!empty) job <= pop_data;
      ST_SQR: begin
        sq_s <= $unsigned(s_w * s_w);
        sq_c <= $unsigned(c_w * c_w);
        x <= x0;
        y <= y0;
        z <= z0;
        zero_vec <= (job.sin_sum == '0) && (job.cos_sum == '0);
      end
      ST_SUM: begin
        rad <= {1'b0, sq_s} + {1'b0, sq_c};
        res <= '0;
      end
      ST_ITER: begin
        if (rad >= trial) begin
          rad <= rad - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        if (cnt < 5'(CordicIters)) begin
          if (y > 0) begin
            x <= x + dx;
            y <= y - dy;
            z <= z + $signed({2'b00, AtanTab[cnt]});
          end else begin
            x <= x - dx;
            y <= y + dy;
            z <= z - $signed({2'b00, AtanTab[cnt]});
          end
        end
        if (cnt == 5'(RootIters - 1)) begin
          if (rad >= trial) begin
            dividend <= DivW'(res >> 1) + DivW'(bitv) + DivW'({job.steps, 6'd0});
          end else begin
            dividend <= DivW'(res >> 1) + DivW'({job.steps, 6'd0});
          end
          rem <= '0;
        end
      end
      ST_DIV: begin
        if (cnt == 5'd0) begin
          if (zero_vec) phase <= '0;
          else if (zq > 34'(PhaseLimit)) phase <= z[33] ? -16'(PhaseLimit) : 16'(PhaseLimit);
          else phase <= z[33] ? -zq[15:0] : zq[15:0];
        end
        if (rem_sh >= {1'b0, job.steps}) begin
          rem <= rem_sh - {1'b0, job.steps};
          dividend <= {dividend[DivW-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          dividend <= {dividend[DivW-2:0], 1'b0};
        end
      end
      ST_OUT: begin
        if (cnt == 5'd0) modu <= (dividend[DivW-1:7] > (DivW-7)'(16'hFFFF)) ? 16'hFFFF
                                : dividend[22:7];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt <= '0;
    end else begin
      case (state)
        ST_IDLE: if (!empty) state <= ST_SQR;
        ST_SQR: state <= ST_SUM;
        ST_SUM: begin
          state <= ST_ITER;
          cnt <= '0;
        end
        ST_ITER: begin
          if (cnt == 5'(RootIters - 1)) begin
            state <= ST_DIV;
            cnt <= '0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_DIV: begin
          if (cnt == 5'(DivW - 1)) begin
            state <= ST_OUT;
            cnt <= '0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_OUT: begin
          cnt <= 5'd1;
          if (m_tready && cnt != 5'd0) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: tb/tb.sv
`default_nettype none
module tb;
  import psd_pkg::*;

  localparam logic [2:0] NUM_STEPS_ADDR = 3'd0;
  localparam longint unsigned PI_Q60 = 64'h3243F6A8885A308D;
  localparam longint unsigned Q60_ONE = 64'h1000000000000000;
  localparam int DRAIN_CYCLES = 200;

  typedef struct packed {
    logic signed [15:0] phase;
    logic [15:0]        modulation;
  } pixel_result_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [7:0] sample
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // [15:0] phase, [31:16] modulation
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  pixel_result_t   pending_pixels[$];
  logic [CfgW-1:0] model_steps;
  logic [3:0]      model_index;
  logic [27:0]     model_sin_sum;
  logic [27:0]     model_cos_sum;
  int              errors = 0;
  int              samples_sent = 0;
  int              pixels_checked = 0;
  int              cfg_writes = 0;
  int              burst_left = 0;
  bit              gaps_on = 1'b0;
  int              stall_pct = 0;

  always #4 clk = ~clk;

  phase_shift_demodulator_core u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  function automatic longint unsigned mul_q60(input longint unsigned a,
                                              input longint unsigned b);
    logic [127:0] p;
    begin
      p = {64'd0, a} * {64'd0, b};
      return p[123:60];
    end
  endfunction

  function automatic int q60_to_q15(input longint v);
    longint unsigned a;
    longint unsigned q;
    begin
      a = (v < 0) ? longint'(-v) : longint'(v);
      q = (a + (64'd1 << 44)) >> 45;
      if (q > 32767) q = 32767;
      return (v < 0) ? -int'(q) : int'(q);
    end
  endfunction

  task automatic fringe_coef(input int unsigned m, input int unsigned n,
                             output int sn, output int cs);
    int unsigned quad;
    int unsigned r;
    longint unsigned theta;
    longint unsigned th2;
    longint unsigned t;
    longint s;
    longint c;
    int s15;
    int c15;
    begin
      quad = (4 * m) / n;
      r = 4 * m - quad * n;
      theta = (PI_Q60 / (2 * longint'(n))) * r;
      th2 = mul_q60(theta, theta);
      t = theta;
      s = longint'(theta);
      c = longint'(Q60_ONE);
      for (int k = 3; k <= 25; k += 2) begin
        t = mul_q60(t, th2) / longint'((k - 1) * k);
        if (((k >> 1) & 1) != 0) s -= longint'(t); else s += longint'(t);
      end
      t = Q60_ONE;
      for (int k = 2; k <= 24; k += 2) begin
        t = mul_q60(t, th2) / longint'((k - 1) * k);
        if (((k >> 1) & 1) != 0) c -= longint'(t); else c += longint'(t);
      end
      s15 = q60_to_q15(s);
      c15 = q60_to_q15(c);
      case (quad & 3)
        0: begin sn = s15; cs = c15; end
        1: begin sn = c15; cs = -s15; end
        2: begin sn = -s15; cs = -c15; end
        default: begin sn = -c15; cs = s15; end
      endcase
    end
  endtask

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    begin
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    end
  endfunction

  function automatic logic signed [15:0] wrapped_phase(input int s, input int c);
    longint x;
    longint y;
    longint z;
    longint xn;
    longint dx;
    longint dy;
    longint a;
    longint q;
    begin
      if (s == 0 && c == 0) return 16'sd0;
      x = longint'(c) * 64'sd4294967296;
      y = -longint'(s) * 64'sd4294967296;
      z = 0;
      if (x < 0) begin
        if (y >= 0) begin
          xn = y; y = -x; z = longint'(HalfPiQ30);
        end else begin
          xn = -y; y = x; z = -longint'(HalfPiQ30);
        end
        x = xn;
      end
      for (int i = 0; i < CordicIters; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y > 0) begin
          x += dx; y -= dy; z += longint'(AtanTab[i]);
        end else begin
          x -= dx; y += dy; z -= longint'(AtanTab[i]);
        end
      end
      a = (z < 0) ? -z : z;
      q = (a + 65536) >>> 17;
      if (q > PhaseLimit) q = PhaseLimit;
      return 16'((z < 0) ? -q : q);
    end
  endfunction

  task automatic accumulate_sample(input logic [7:0] sample);
    int unsigned n;
    int sn;
    int cs;
    int s;
    int c;
    longint unsigned r;
    longint unsigned md;
    pixel_result_t res;
    begin
      n = model_steps;
      if (n < 3) n = 3;
      if (n > 16) n = 16;
      fringe_coef((model_index + 1) % n, n, sn, cs);
      model_sin_sum = model_sin_sum + 28'(int'(sample) * sn);
      model_cos_sum = model_cos_sum + 28'(int'(sample) * cs);
      if (model_index + 1 < n) begin
        model_index = model_index + 1;
      end else begin
        s = int'(signed'(model_sin_sum));
        c = int'(signed'(model_cos_sum));
        r = int_sqrt(longint'(s) * s + longint'(c) * c);
        md = (r + 64 * n) / (128 * n);
        if (md > 65535) md = 65535;
        res.phase = wrapped_phase(s, c);
        res.modulation = md[15:0];
        pending_pixels.push_back(res);
        model_index = 0;
        model_sin_sum = 0;
        model_cos_sum = 0;
      end
    end
  endtask

  always @(posedge clk) begin
    pixel_result_t want;
    if (!rst) begin
      if (psel && penable && pwrite && pready && paddr == NUM_STEPS_ADDR)
        model_steps = pwdata[CfgW-1:0];
      if (s_tvalid && s_tready) accumulate_sample(s_tdata);
      if (m_tvalid && m_tready) begin
        if (pending_pixels.size() == 0) begin
          $error("result transfer with nothing expected: %h", m_tdata);
          errors++;
        end else begin
          want = pending_pixels.pop_front();
          pixels_checked++;
          if (m_tdata[15:0] !== want.phase) begin
            $error("phase expected %0d actual %0d", want.phase, $signed(m_tdata[15:0]));
            errors++;
          end
          if (m_tdata[31:16] !== want.modulation) begin
            $error("modulation expected %0d actual %0d", want.modulation, m_tdata[31:16]);
            errors++;
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic send_sample(input logic [7:0] v);
    begin
      if (gaps_on && burst_left == 0) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat ($urandom_range(0, 6)) @(negedge clk);
        burst_left = $urandom_range(1, 24);
      end
      if (burst_left > 0) burst_left--;
      @(negedge clk);
      s_tvalid <= 1'b1;
      s_tdata <= v;
      do @(posedge clk); while (!s_tready);
      samples_sent++;
    end
  endtask

  task automatic wait_idle();
    begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clk);
      repeat (DRAIN_CYCLES) @(posedge clk);
    end
  endtask

  task automatic write_steps(input logic [CfgW-1:0] v);
    begin
      wait_idle();
      @(negedge clk);
      psel <= 1'b1;
      pwrite <= 1'b1;
      paddr <= NUM_STEPS_ADDR;
      pwdata <= 32'(v);
      @(negedge clk);
      penable <= 1'b1;
      @(negedge clk);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      cfg_writes++;
    end
  endtask

  task automatic send_pixel(input int n, input int style);
    begin
      for (int k = 0; k < n; k++) begin
        case (style)
          0: send_sample(8'($urandom));
          1: send_sample($urandom_range(0, 1) ? 8'hFF : 8'h00);
          default: send_sample(8'($urandom_range(100, 140)));
        endcase
      end
    end
  endtask

  task automatic test_extremes();
    begin
      write_steps(5'd4);
      send_pixel(4, 1);
      for (int k = 0; k < 4; k++) send_sample(8'hFF);
      send_sample(8'hFF); send_sample(8'h00); send_sample(8'h00); send_sample(8'h00);
      send_sample(8'h00); send_sample(8'hFF); send_sample(8'h00); send_sample(8'h00);
    end
  endtask

  task automatic test_special_vectors();
    begin
      for (int k = 0; k < 4; k++) send_sample(8'h00);
      send_sample(8'h40); send_sample(8'hFF); send_sample(8'h40); send_sample(8'h00);
      send_sample(8'h00); send_sample(8'h00); send_sample(8'hFF); send_sample(8'h00);
    end
  endtask

  task automatic test_out_of_range_steps();
    begin
      write_steps(5'd0);
      send_pixel(3, 0);
      write_steps(5'd2);
      send_pixel(3, 1);
      write_steps(5'd31);
      send_pixel(16, 1);
      write_steps(5'd16);
      for (int k = 0; k < 16; k++) send_sample(8'hFF);
    end
  endtask

  task automatic test_mid_pixel_change();
    begin
      write_steps(5'd8);
      send_pixel(5, 0);
      write_steps(5'd3);
      send_pixel(1, 0);
      send_pixel(3, 0);
    end
  endtask

  task automatic test_random_pixels();
    int n;
    int r;
    begin
      for (int ph = 0; ph < 10; ph++) begin
        if (ph == 0) n = 3;
        else if (ph == 1) n = 16;
        else n = $urandom_range(3, 16);
        write_steps(5'(n));
        gaps_on = (ph % 3) != 0;
        stall_pct = (ph % 4 == 0) ? 0 : $urandom_range(10, 90);
        while (samples_sent < 60 + (ph + 1) * 160) begin
          r = $urandom_range(0, 9);
          if (r < 7) send_pixel(n, 0);
          else if (r < 9) send_pixel(n, r - 6);
          else send_pixel($urandom_range(1, n - 1), 0);
        end
        n = model_index;
        if (n != 0) send_pixel(model_steps - n, 0);
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = NUM_STEPS_ADDR;
    pwdata = '0;
    model_steps = StepsReset;
    model_index = 0;
    model_sin_sum = 0;
    model_cos_sum = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_extremes();
    test_special_vectors();
    test_out_of_range_steps();
    test_mid_pixel_change();
    test_random_pixels();
    wait_idle();
    $display("Sent %0d samples over %0d step-count writes; checked %0d pixel results.",
             samples_sent, cfg_writes, pixels_checked);
    if (errors == 0 && pending_pixels.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
`default_nettype wire
